[hw/rtl/etlf_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants and register indexes of the EMA trend load forecaster.
package etlf_pkg;

    // Field widths
    localparam int SAMPLE_W  = 15;
    localparam int LEVEL_W   = 23;
    localparam int SLOPE_W   = 24;
    localparam int HELD_W    = 6;
    localparam int ALPHA_W   = 16;
    localparam int HORIZON_W = 8;
    localparam int MIN_W     = 6;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TREND = 2'd2;

    localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 16'd19661;
    localparam logic [HORIZON_W-1:0] HORIZON_RESET = 8'd60;
    localparam logic [MIN_W-1:0]     MIN_RESET     = 6'd10;

    // 100 percent in Q7.8
    localparam int FULL_SCALE = 25600;

    // Shared multiplier: signed operands, full product
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Slope magnitude never reaches 2^23 (256 * full scale bounds it)
    localparam int QUO_W = 23;

    // Forecast sum: level plus slope times horizon, signed
    localparam int FC_W = 34;

endpackage

[hw/rtl/etlf_hist.sv]
`timescale 1ns / 1ps
// Sample history memory: one cpu/mem pair per entry, one address, registered read.
module etlf_hist #(
    parameter int DEPTH  = 60,
    parameter int ADDR_W = 6
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             addr,
    input  logic [etlf_pkg::SAMPLE_W-1:0] wr_cpu,
    input  logic [etlf_pkg::SAMPLE_W-1:0] wr_mem,
    output logic [etlf_pkg::SAMPLE_W-1:0] rd_cpu,
    output logic [etlf_pkg::SAMPLE_W-1:0] rd_mem
);

    logic [2*etlf_pkg::SAMPLE_W-1:0] hist_mem [DEPTH];
    logic [2*etlf_pkg::SAMPLE_W-1:0] rd_reg;

    // Read-before-write: a read at the written address returns the old entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[addr] <= {wr_cpu, wr_mem};
        end
        rd_reg <= hist_mem[addr];
    end

    assign rd_cpu = rd_reg[2*etlf_pkg::SAMPLE_W-1:etlf_pkg::SAMPLE_W];
    assign rd_mem = rd_reg[etlf_pkg::SAMPLE_W-1:0];

endmodule

[hw/rtl/etlf_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module etlf_mul (
    input  logic                               clk,
    input  logic signed [etlf_pkg::MUL_W-1:0]  op_a,
    input  logic signed [etlf_pkg::MUL_W-1:0]  op_b,
    output logic signed [etlf_pkg::PROD_W-1:0] prod
);

    logic signed [etlf_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/etlf_div.sv]
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, quotient known to fit QUO_W bits.
module etlf_div #(
    parameter int DVD_W = 50,
    parameter int DVS_W = 28
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [DVD_W-1:0]                 dividend,
    input  logic [DVS_W-1:0]                 divisor,
    output logic                             busy,
    output logic [etlf_pkg::QUO_W-1:0]       quotient
);

    localparam int Q_W   = etlf_pkg::QUO_W;
    localparam int SH_W  = DVS_W + Q_W;
    localparam int W     = (DVD_W > SH_W) ? DVD_W : SH_W;
    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsh_reg;
    logic [Q_W-1:0]   quo_reg;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(Q_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Shift the divisor down one place a step; subtract where it fits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= W'(dividend);
            dsh_reg <= W'(divisor) << (Q_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[Q_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/ema_trend_load_forecaster_core.sv]
`timescale 1ns / 1ps
// EMA trend load forecaster top: sequencer, running sums, level, slope and forecast.
// A beat is taken only from idle, so a new sample waits until the last result is handed off.
// The two slope divisions, 23 steps each through the one shared divider, set the rate.
// All other products go one per cycle through the one shared multiplier.
// Reset (rst_n, async, low): empty window, unseeded level, default config; no clearing pass.
module ema_trend_load_forecaster_core #(
    parameter int WINDOW_DEPTH = 60
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Configuration writes
    input  logic                                  cfg_write,
    input  logic [etlf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [etlf_pkg::CFG_W-1:0]            cfg_data,

    // Sample channel
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic [etlf_pkg::SAMPLE_W-1:0]         cpu_sample,
    input  logic [etlf_pkg::SAMPLE_W-1:0]         mem_sample,

    // Result channel
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [etlf_pkg::SAMPLE_W-1:0]         cpu_forecast,
    output logic [etlf_pkg::SAMPLE_W-1:0]         mem_forecast,
    output logic signed [etlf_pkg::SLOPE_W-1:0]   cpu_slope,
    output logic signed [etlf_pkg::SLOPE_W-1:0]   mem_slope,
    output logic [etlf_pkg::LEVEL_W-1:0]          cpu_level,
    output logic [etlf_pkg::LEVEL_W-1:0]          mem_level,
    output logic [etlf_pkg::HELD_W-1:0]           samples_held
);

    // ------------------------------------------------------------------
    // Widths that follow from the window depth
    // ------------------------------------------------------------------
    localparam int SAMPLE_W = etlf_pkg::SAMPLE_W;
    localparam int LEVEL_W  = etlf_pkg::LEVEL_W;
    localparam int SLOPE_W  = etlf_pkg::SLOPE_W;
    localparam int MUL_W    = etlf_pkg::MUL_W;
    localparam int PROD_W   = etlf_pkg::PROD_W;
    localparam int FC_W     = etlf_pkg::FC_W;
    localparam int MIN_W    = etlf_pkg::MIN_W;

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SY_W   = $clog2(WINDOW_DEPTH * etlf_pkg::FULL_SCALE + 1);
    localparam int SXY_W  =
        $clog2((WINDOW_DEPTH * (WINDOW_DEPTH - 1) / 2) * etlf_pkg::FULL_SCALE + 1);
    localparam int SQ_W   = 2 * CNT_W;           // n*n and n(n-1)/2
    localparam int DEN_W  = 4 * CNT_W;           // n*n*(n*n-1)
    localparam int MAG_W  = CNT_W + SXY_W;       // |n*Sxy - Sx*Sy|
    localparam int NUM_W  = MAG_W + 1;
    localparam int DVD_W  = MAG_W + 12;          // |num| * 3072
    localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

    // ------------------------------------------------------------------
    // Sequencer states, one-hot
    // ------------------------------------------------------------------
    typedef enum logic [21:0] {
        ST_IDLE    = 22'h000001,
        ST_XY_C    = 22'h000002,  // issue weight * cpu sample
        ST_XY_M    = 22'h000004,  // update cpu sums, issue weight * mem sample
        ST_PUSH    = 22'h000008,  // update mem sums, write history, issue n*n
        ST_NSQ     = 22'h000010,  // hold n*n, issue n*(n-1)
        ST_SX      = 22'h000020,  // hold Sx, issue n2*(n2-1)
        ST_DEN     = 22'h000040,  // hold divisor, issue n*Sxy (cpu)
        ST_NUM_C0  = 22'h000080,  // issue Sx*Sy (cpu)
        ST_NUM_C1  = 22'h000100,  // form cpu numerator, issue n*Sxy (mem)
        ST_NUM_M0  = 22'h000200,  // cpu magnitude, issue Sx*Sy (mem)
        ST_NUM_M1  = 22'h000400,  // start cpu division, form mem numerator
        ST_EMA_C0  = 22'h000800,  // mem magnitude, EMA cpu terms
        ST_EMA_C1  = 22'h001000,
        ST_EMA_M0  = 22'h002000,
        ST_EMA_M1  = 22'h004000,
        ST_WAIT_C  = 22'h008000,  // wait cpu quotient, start mem division
        ST_FC_C0   = 22'h010000,  // issue cpu slope * horizon
        ST_FC_C1   = 22'h020000,
        ST_WAIT_M  = 22'h040000,  // wait mem quotient
        ST_FC_M0   = 22'h080000,
        ST_FC_M1   = 22'h100000,
        ST_DONE    = 22'h200000   // hand off to the result register
    } state_t;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t state_reg;

    logic [etlf_pkg::ALPHA_W-1:0]   alpha_reg;
    logic [etlf_pkg::HORIZON_W-1:0] horizon_reg;
    logic [MIN_W-1:0]               min_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              seeded_reg;
    logic [LEVEL_W-1:0] cpu_avg_reg;
    logic [LEVEL_W-1:0] mem_avg_reg;
    logic [SY_W-1:0]   cpu_sy_reg;
    logic [SY_W-1:0]   mem_sy_reg;
    logic [SXY_W-1:0]  cpu_sxy_reg;
    logic [SXY_W-1:0]  mem_sxy_reg;

    logic [SY_W-1:0]   cpu_sy_next;
    logic [SY_W-1:0]   mem_sy_next;
    logic [SXY_W-1:0]  cpu_sxy_next;
    logic [SXY_W-1:0]  mem_sxy_next;
    logic [SY_W-1:0]   cpu_rest;
    logic [SY_W-1:0]   mem_rest;

    logic [SAMPLE_W-1:0] c_reg;
    logic [SAMPLE_W-1:0] m_reg;
    logic [SQ_W-1:0]     n2_reg;
    logic [SQ_W-1:0]     sx_reg;
    logic [DEN_W-1:0]    den_reg;
    logic signed [PROD_W-1:0] tmp_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic                cpu_neg_reg;
    logic                mem_neg_reg;
    logic signed [SLOPE_W-1:0] cpu_slope_reg;
    logic signed [SLOPE_W-1:0] mem_slope_reg;
    logic [SAMPLE_W-1:0] cpu_fc_reg;
    logic [SAMPLE_W-1:0] mem_fc_reg;

    logic                      result_valid_reg;
    logic [SAMPLE_W-1:0]       out_cpu_fc_reg;
    logic [SAMPLE_W-1:0]       out_mem_fc_reg;
    logic signed [SLOPE_W-1:0] out_cpu_slope_reg;
    logic signed [SLOPE_W-1:0] out_mem_slope_reg;
    logic [LEVEL_W-1:0]        out_cpu_level_reg;
    logic [LEVEL_W-1:0]        out_mem_level_reg;
    logic [etlf_pkg::HELD_W-1:0] out_held_reg;

    logic                 full;
    logic [CNT_W-1:0]     weight;
    logic [CNT_W-1:0]     n_new;
    logic                 trend_en;
    logic                 sample_acc;
    logic                 result_load;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                 div_start;
    logic                 div_busy;
    logic [DVD_W-1:0]     div_dividend;
    logic [etlf_pkg::QUO_W-1:0] div_quotient;
    logic signed [SLOPE_W-1:0]  quo_ext;
    logic signed [PROD_W-1:0]   ema_sum;
    logic signed [PROD_W-1:0]   num_full;

    logic [SAMPLE_W-1:0]  old_c;
    logic [SAMPLE_W-1:0]  old_m;
    logic                 hist_we;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Saturate a raw sample to 100 percent.
    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] lim;
        lim = SAMPLE_W'(etlf_pkg::FULL_SCALE);
        return (v > lim) ? lim : v;
    endfunction

    // level + slope*horizon in Q.16, floored to Q.8 and clamped to 0..100%.
    function automatic logic [SAMPLE_W-1:0] forecast_of(
        input logic [LEVEL_W-1:0]       level,
        input logic signed [PROD_W-1:0] term
    );
        logic signed [FC_W-1:0] p;
        logic [FC_W-9:0]        q;
        logic [SAMPLE_W-1:0]    r;
        p = $signed({{(FC_W - LEVEL_W){1'b0}}, level}) + $signed(term[FC_W-1:0]);
        q = p[FC_W-1:8];
        if (p <= 0)
        begin
            r = '0;
        end
        else if (q > (FC_W-8)'(etlf_pkg::FULL_SCALE))
        begin
            r = SAMPLE_W'(etlf_pkg::FULL_SCALE);
        end
        else
        begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // Take one beat only when the sequencer is parked.
    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_acc   = sample_valid && !sample_stall;

    // The result register takes a new beat when empty or being drained.
    assign result_load  = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    // ------------------------------------------------------------------
    // Window bookkeeping
    // ------------------------------------------------------------------
    assign full     = (fill_reg == CNT_W'(WINDOW_DEPTH));
    // Position weight of the new sample: count before the push, or the last
    // position once the window is full.
    assign weight   = full ? CNT_W'(WINDOW_DEPTH - 1) : fill_reg;
    assign n_new    = full ? fill_reg : (fill_reg + CNT_W'(1));
    // No slope below the minimum count, and never from a single sample.
    assign trend_en = (CMP_W'(fill_reg) >= CMP_W'(min_reg)) && (fill_reg >= CNT_W'(2));

    // Running sums. Once the window is full, drop the oldest sample: every
    // remaining x moves down by one, so Sxy loses the rest of Sy.
    always_comb
    begin
        cpu_rest = cpu_sy_reg - SY_W'(old_c);
        mem_rest = mem_sy_reg - SY_W'(old_m);
        if (!full)
        begin
            cpu_sy_next  = cpu_sy_reg + SY_W'(c_reg);
            cpu_sxy_next = cpu_sxy_reg + prod[SXY_W-1:0];
            mem_sy_next  = mem_sy_reg + SY_W'(m_reg);
            mem_sxy_next = mem_sxy_reg + prod[SXY_W-1:0];
        end
        else
        begin
            cpu_sy_next  = cpu_rest + SY_W'(c_reg);
            cpu_sxy_next = cpu_sxy_reg - SXY_W'(cpu_rest) + prod[SXY_W-1:0];
            mem_sy_next  = mem_rest + SY_W'(m_reg);
            mem_sxy_next = mem_sxy_reg - SXY_W'(mem_rest) + prod[SXY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand select: one product per state, consumed
    // in the state that follows.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_XY_C:
            begin
                mul_a = MUL_W'(weight);
                mul_b = MUL_W'(c_reg);
            end
            ST_XY_M:
            begin
                mul_a = MUL_W'(weight);
                mul_b = MUL_W'(m_reg);
            end
            ST_PUSH:
            begin
                mul_a = MUL_W'(n_new);
                mul_b = MUL_W'(n_new);
            end
            ST_NSQ:
            begin
                mul_a = MUL_W'(fill_reg);
                mul_b = MUL_W'(fill_reg - CNT_W'(1));
            end
            ST_SX:
            begin
                mul_a = MUL_W'(n2_reg);
                mul_b = MUL_W'(n2_reg - SQ_W'(1));
            end
            ST_DEN:
            begin
                mul_a = MUL_W'(fill_reg);
                mul_b = MUL_W'(cpu_sxy_reg);
            end
            ST_NUM_C0:
            begin
                mul_a = MUL_W'(sx_reg);
                mul_b = MUL_W'(cpu_sy_reg);
            end
            ST_NUM_C1:
            begin
                mul_a = MUL_W'(fill_reg);
                mul_b = MUL_W'(mem_sxy_reg);
            end
            ST_NUM_M0:
            begin
                mul_a = MUL_W'(sx_reg);
                mul_b = MUL_W'(mem_sy_reg);
            end
            ST_NUM_M1:
            begin
                mul_a = MUL_W'(alpha_reg);
                mul_b = MUL_W'({c_reg, 8'd0});
            end
            ST_EMA_C0:
            begin
                mul_a = MUL_W'(17'h10000 - 17'(alpha_reg));
                mul_b = MUL_W'(cpu_avg_reg);
            end
            ST_EMA_C1:
            begin
                mul_a = MUL_W'(alpha_reg);
                mul_b = MUL_W'({m_reg, 8'd0});
            end
            ST_EMA_M0:
            begin
                mul_a = MUL_W'(17'h10000 - 17'(alpha_reg));
                mul_b = MUL_W'(mem_avg_reg);
            end
            ST_FC_C0:
            begin
                mul_a = MUL_W'(cpu_slope_reg);
                mul_b = MUL_W'(horizon_reg);
            end
            ST_FC_M0:
            begin
                mul_a = MUL_W'(mem_slope_reg);
                mul_b = MUL_W'(horizon_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    etlf_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // ------------------------------------------------------------------
    // Slope division: 256*num/D == 3072*num / (n*n*(n*n-1)), exact, so the
    // constant /12 folds into the dividend. Divide magnitudes, sign later.
    // ------------------------------------------------------------------
    assign div_start    = (state_reg == ST_NUM_M1) ||
                          ((state_reg == ST_WAIT_C) && !div_busy);
    assign div_dividend = {(MAG_W+2)'(mag_reg) + {1'b0, mag_reg, 1'b0}, 10'd0};

    etlf_div #(
        .DVD_W (DVD_W),
        .DVS_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign quo_ext  = SLOPE_W'(div_quotient);
    assign ema_sum  = tmp_reg + prod;
    assign num_full = tmp_reg - prod;

    // ------------------------------------------------------------------
    // History
    // ------------------------------------------------------------------
    assign hist_we = (state_reg == ST_PUSH);

    etlf_hist #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_hist (
        .clk    (clk),
        .wr_en  (hist_we),
        .addr   (slot_reg),
        .wr_cpu (c_reg),
        .wr_mem (m_reg),
        .rd_cpu (old_c),
        .rd_mem (old_m)
    );

    // ------------------------------------------------------------------
    // Control and persistent state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            alpha_reg        <= etlf_pkg::ALPHA_RESET;
            horizon_reg      <= etlf_pkg::HORIZON_RESET;
            min_reg          <= etlf_pkg::MIN_RESET;
            slot_reg         <= '0;
            fill_reg         <= '0;
            seeded_reg       <= 1'b0;
            cpu_avg_reg      <= '0;
            mem_avg_reg      <= '0;
            cpu_sy_reg       <= '0;
            mem_sy_reg       <= '0;
            cpu_sxy_reg      <= '0;
            mem_sxy_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    etlf_pkg::CFG_ALPHA:     alpha_reg   <= cfg_data;
                    etlf_pkg::CFG_HORIZON:   horizon_reg <= cfg_data[etlf_pkg::HORIZON_W-1:0];
                    etlf_pkg::CFG_MIN_TREND: min_reg     <= cfg_data[MIN_W-1:0];
                    default:                 alpha_reg   <= alpha_reg;
                endcase
            end

            // Drop the held result once the sink takes it.
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_acc)
                    begin
                        state_reg <= ST_XY_C;
                    end
                end
                ST_XY_C:   state_reg <= ST_XY_M;
                ST_XY_M:
                begin
                    cpu_sy_reg  <= cpu_sy_next;
                    cpu_sxy_reg <= cpu_sxy_next;
                    state_reg   <= ST_PUSH;
                end
                ST_PUSH:
                begin
                    mem_sy_reg  <= mem_sy_next;
                    mem_sxy_reg <= mem_sxy_next;
                    fill_reg    <= n_new;
                    slot_reg    <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ?
                                   '0 : (slot_reg + SLOT_W'(1));
                    state_reg   <= ST_NSQ;
                end
                ST_NSQ:    state_reg <= ST_SX;
                ST_SX:     state_reg <= ST_DEN;
                ST_DEN:    state_reg <= ST_NUM_C0;
                ST_NUM_C0: state_reg <= ST_NUM_C1;
                ST_NUM_C1: state_reg <= ST_NUM_M0;
                ST_NUM_M0: state_reg <= ST_NUM_M1;
                ST_NUM_M1: state_reg <= ST_EMA_C0;
                ST_EMA_C0: state_reg <= ST_EMA_C1;
                ST_EMA_C1:
                begin
                    // First sample seeds the level directly.
                    cpu_avg_reg <= seeded_reg ? ema_sum[LEVEL_W+15:16] : {c_reg, 8'd0};
                    state_reg   <= ST_EMA_M0;
                end
                ST_EMA_M0: state_reg <= ST_EMA_M1;
                ST_EMA_M1:
                begin
                    mem_avg_reg <= seeded_reg ? ema_sum[LEVEL_W+15:16] : {m_reg, 8'd0};
                    seeded_reg  <= 1'b1;
                    state_reg   <= ST_WAIT_C;
                end
                ST_WAIT_C:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_FC_C0;
                    end
                end
                ST_FC_C0:  state_reg <= ST_FC_C1;
                ST_FC_C1:  state_reg <= ST_WAIT_M;
                ST_WAIT_M:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_FC_M0;
                    end
                end
                ST_FC_M0:  state_reg <= ST_FC_M1;
                ST_FC_M1:  state_reg <= ST_DONE;
                ST_DONE:
                begin
                    // Hold here while the previous result is still stalled.
                    if (result_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Working registers and result payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            c_reg <= sat_sample(cpu_sample);
            m_reg <= sat_sample(mem_sample);
        end

        case (state_reg)
            ST_NSQ:    n2_reg  <= prod[SQ_W-1:0];
            ST_SX:     sx_reg  <= prod[SQ_W:1];
            ST_DEN:    den_reg <= prod[DEN_W-1:0];
            ST_NUM_C0: tmp_reg <= prod;
            ST_NUM_C1: num_reg <= num_full[NUM_W-1:0];
            ST_NUM_M0:
            begin
                tmp_reg     <= prod;
                cpu_neg_reg <= num_reg[NUM_W-1];
                mag_reg     <= num_reg[NUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
            end
            ST_NUM_M1: num_reg <= num_full[NUM_W-1:0];
            ST_EMA_C0:
            begin
                tmp_reg     <= prod;
                mem_neg_reg <= num_reg[NUM_W-1];
                mag_reg     <= num_reg[NUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
            end
            ST_EMA_M0: tmp_reg <= prod;
            ST_WAIT_C:
            begin
                if (!div_busy)
                begin
                    cpu_slope_reg <= !trend_en ? '0 : (cpu_neg_reg ? -quo_ext : quo_ext);
                end
            end
            ST_FC_C1:  cpu_fc_reg <= forecast_of(cpu_avg_reg, prod);
            ST_WAIT_M:
            begin
                if (!div_busy)
                begin
                    mem_slope_reg <= !trend_en ? '0 : (mem_neg_reg ? -quo_ext : quo_ext);
                end
            end
            ST_FC_M1:  mem_fc_reg <= forecast_of(mem_avg_reg, prod);
            default:   tmp_reg <= tmp_reg;
        endcase

        if (result_load)
        begin
            out_cpu_fc_reg    <= cpu_fc_reg;
            out_mem_fc_reg    <= mem_fc_reg;
            out_cpu_slope_reg <= cpu_slope_reg;
            out_mem_slope_reg <= mem_slope_reg;
            out_cpu_level_reg <= cpu_avg_reg;
            out_mem_level_reg <= mem_avg_reg;
            out_held_reg      <= etlf_pkg::HELD_W'(fill_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign cpu_forecast = out_cpu_fc_reg;
    assign mem_forecast = out_mem_fc_reg;
    assign cpu_slope    = out_cpu_slope_reg;
    assign mem_slope    = out_mem_slope_reg;
    assign cpu_level    = out_cpu_level_reg;
    assign mem_level    = out_mem_level_reg;
    assign samples_held = out_held_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window count above depth");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW_DEPTH - 1))
        else $error("write slot out of range");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> (sample_stall && !result_load))
        else $error("sample taken while a beat is in flight");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside hand-off");

endmodule

[bench/ema_trend_load_forecaster_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the EMA trend load forecaster: directed table, random trend bursts.
module ema_trend_load_forecaster_core_tb;

    localparam int SAMPLE_W   = etlf_pkg::SAMPLE_W;
    localparam int SLOPE_W    = etlf_pkg::SLOPE_W;
    localparam int LEVEL_W    = etlf_pkg::LEVEL_W;
    localparam int HELD_W     = etlf_pkg::HELD_W;
    localparam int CFG_W      = etlf_pkg::CFG_W;
    localparam int CFG_IDX_W  = etlf_pkg::CFG_IDX_W;
    localparam int ALPHA_W    = etlf_pkg::ALPHA_W;
    localparam int HORIZON_W  = etlf_pkg::HORIZON_W;
    localparam int MIN_W      = etlf_pkg::MIN_W;
    localparam int FULL_SCALE = etlf_pkg::FULL_SCALE;

    localparam int DEPTH           = 60;
    // Response time of the block to a beat; wait a little longer at the end.
    localparam int LATENCY         = 61;
    localparam int DRAIN_CYCLES    = LATENCY + 16;
    // Slowest legal run: ~920 beats, each with the longest input gap, the busy time and
    // the longest receiver stall. Allow several times that.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 112;

    // One forecast beat as the block presents it.
    typedef struct {
        logic [SAMPLE_W-1:0]       cpu_fc;
        logic [SAMPLE_W-1:0]       mem_fc;
        logic signed [SLOPE_W-1:0] cpu_sl;
        logic signed [SLOPE_W-1:0] mem_sl;
        logic [LEVEL_W-1:0]        cpu_lv;
        logic [LEVEL_W-1:0]        mem_lv;
        logic [HELD_W-1:0]         held;
    } forecast_t;

    // One row of the directed table: a register write, or a sample beat
    // with an optional hand-computed forecast.
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [SAMPLE_W-1:0]  cpu;
        logic [SAMPLE_W-1:0]  mem;
        bit                   typed;
        forecast_t            want;
    } plan_row_t;

    // Shapes of the random sample bursts.
    typedef enum int {SHAPE_RAMP, SHAPE_SPREAD, SHAPE_NOISE, SHAPE_FLAT} shape_t;

    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [CFG_W-1:0]            cfg_data     = '0;
    logic                        sample_valid = 1'b0;
    logic                        sample_stall;
    logic [SAMPLE_W-1:0]         cpu_sample   = '0;
    logic [SAMPLE_W-1:0]         mem_sample   = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic [SAMPLE_W-1:0]         cpu_forecast;
    logic [SAMPLE_W-1:0]         mem_forecast;
    logic signed [SLOPE_W-1:0]   cpu_slope;
    logic signed [SLOPE_W-1:0]   mem_slope;
    logic [LEVEL_W-1:0]          cpu_level;
    logic [LEVEL_W-1:0]          mem_level;
    logic [HELD_W-1:0]           samples_held;

    // Shadow of the configuration registers, updated as they are written.
    logic [ALPHA_W-1:0]   alpha_q     = etlf_pkg::ALPHA_RESET;
    logic [HORIZON_W-1:0] horizon_q   = etlf_pkg::HORIZON_RESET;
    logic [MIN_W-1:0]     min_trend_q = etlf_pkg::MIN_RESET;

    // Forecaster state; index 0 is cpu, index 1 is mem.
    logic [SAMPLE_W-1:0] history [2][DEPTH];
    int                  write_pos    = 0;
    int                  held_count   = 0;
    bit                  level_seeded = 1'b0;
    longint              level_q16 [2] = '{0, 0};
    longint              sum_y [2]     = '{0, 0};
    longint              sum_xy [2]    = '{0, 0};

    // Forecasts still owed by the block, oldest first.
    forecast_t pending_forecasts [$];
    int        error_count = 0;
    int        cycle_count = 0;

    // Burst state of the random part. quiet turns off idling on both sides.
    bit     quiet       = 1'b0;
    shape_t shape       = SHAPE_RAMP;
    int     burst_left  = 0;
    int     track [2]   = '{0, 0};
    int     drift [2]   = '{0, 0};

    ema_trend_load_forecaster_core #(
        .WINDOW_DEPTH (DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cpu_sample   (cpu_sample),
        .mem_sample   (mem_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cpu_forecast (cpu_forecast),
        .mem_forecast (mem_forecast),
        .cpu_slope    (cpu_slope),
        .mem_slope    (mem_slope),
        .cpu_level    (cpu_level),
        .mem_level    (mem_level),
        .samples_held (samples_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Forecast predictor
    // ------------------------------------------------------------------

    // Clip a sample above 100% to full scale.
    function automatic longint saturate(logic [SAMPLE_W-1:0] raw);
        return (raw > FULL_SCALE) ? longint'(FULL_SCALE) : longint'(raw);
    endfunction

    // Least-squares slope in Q.16 over the held window, truncated toward zero.
    // Report zero until enough samples are held.
    function automatic longint trend_slope(int ch);
        longint n;
        longint floor_n;
        longint sx;
        longint den;
        longint num;
        n       = held_count;
        floor_n = min_trend_q;
        if (n < floor_n || n < 2)
            return 0;
        sx  = n * (n - 1) / 2;
        den = n * n * (n * n - 1) / 12;
        num = n * sum_xy[ch] - sx * sum_y[ch];
        return (num * 256) / den;
    endfunction

    // Extend the level along the slope, floor to Q.8 and clamp to 0..100%.
    function automatic logic [SAMPLE_W-1:0] project(longint level, longint slope);
        longint hz;
        longint p;
        hz = horizon_q;
        p  = level + slope * hz;
        if (p <= 0)
            return '0;
        p = p >>> 8;
        if (p > FULL_SCALE)
            p = FULL_SCALE;
        return p[SAMPLE_W-1:0];
    endfunction

    // Take one sample pair into the window, sums and level; return the forecast beat.
    function automatic forecast_t predict_forecast(logic [SAMPLE_W-1:0] cpu_raw,
                                                   logic [SAMPLE_W-1:0] mem_raw);
        longint    s [2];
        longint    slope [2];
        longint    rest;
        longint    a;
        int        ch;
        forecast_t r;
        s[0] = saturate(cpu_raw);
        s[1] = saturate(mem_raw);
        a    = alpha_q;
        for (ch = 0; ch < 2; ch++)
        begin
            if (held_count < DEPTH)
            begin
                // Window still filling: the new sample sits at x = held_count.
                sum_y[ch]  += s[ch];
                sum_xy[ch] += held_count * s[ch];
            end
            else
            begin
                // Window full: drop the oldest and shift every x down by one.
                rest       = sum_y[ch] - history[ch][write_pos];
                sum_xy[ch] = sum_xy[ch] - rest + (DEPTH - 1) * s[ch];
                sum_y[ch]  = rest + s[ch];
            end
            history[ch][write_pos] = s[ch][SAMPLE_W-1:0];
            if (!level_seeded)
                level_q16[ch] = s[ch] << 8;
            else
                level_q16[ch] = (a * (s[ch] << 8) + (65536 - a) * level_q16[ch]) >>> 16;
        end
        write_pos    = (write_pos + 1) % DEPTH;
        level_seeded = 1'b1;
        if (held_count < DEPTH)
            held_count++;
        for (ch = 0; ch < 2; ch++)
            slope[ch] = trend_slope(ch);
        r.cpu_fc = project(level_q16[0], slope[0]);
        r.mem_fc = project(level_q16[1], slope[1]);
        r.cpu_sl = slope[0][SLOPE_W-1:0];
        r.mem_sl = slope[1][SLOPE_W-1:0];
        r.cpu_lv = level_q16[0][LEVEL_W-1:0];
        r.mem_lv = level_q16[1][LEVEL_W-1:0];
        r.held   = held_count[HELD_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    function automatic plan_row_t beat(logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] m);
        plan_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = etlf_pkg::CFG_ALPHA;
        r.reg_val = '0;
        r.cpu     = c;
        r.mem     = m;
        r.typed   = 1'b0;
        return r;
    endfunction

    // Sample beat whose forecast is written out by hand; slopes are zero here.
    function automatic plan_row_t checked(logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] m,
                                          logic [SAMPLE_W-1:0] cfc, logic [SAMPLE_W-1:0] mfc,
                                          logic [LEVEL_W-1:0] clv, logic [LEVEL_W-1:0] mlv,
                                          logic [HELD_W-1:0] held);
        plan_row_t r;
        r             = beat(c, m);
        r.typed       = 1'b1;
        r.want.cpu_fc = cfc;
        r.want.mem_fc = mfc;
        r.want.cpu_sl = '0;
        r.want.mem_sl = '0;
        r.want.cpu_lv = clv;
        r.want.mem_lv = mlv;
        r.want.held   = held;
        return r;
    endfunction

    function automatic plan_row_t setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        plan_row_t r;
        r         = beat('0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random sample shaping
    // ------------------------------------------------------------------

    // Next sample of one channel for the current burst. Ramps bounce off
    // 0 and 100% with a little jitter; noise covers the whole 15-bit field.
    function automatic logic [SAMPLE_W-1:0] next_sample(int ch);
        int v;
        case (shape)
            SHAPE_RAMP:
            begin
                track[ch] += drift[ch];
                if (track[ch] > FULL_SCALE || track[ch] < 0)
                begin
                    drift[ch] = -drift[ch];
                    track[ch] = (track[ch] < 0) ? 0 : FULL_SCALE;
                end
                v = track[ch] + $urandom_range(0, 128) - 64;
            end
            SHAPE_SPREAD: v = $urandom_range(0, FULL_SCALE);
            SHAPE_NOISE:  v = $urandom_range(0, 32767);
            default:      v = track[ch];
        endcase
        if (v < 0)
            v = 0;
        if (shape != SHAPE_NOISE && v > FULL_SCALE)
            v = FULL_SCALE;
        return v[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Write one register. Only called with the block idle; hold the write
    // enable high so back-to-back writes need no gap.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            etlf_pkg::CFG_ALPHA:     alpha_q     = value[ALPHA_W-1:0];
            etlf_pkg::CFG_HORIZON:   horizon_q   = value[HORIZON_W-1:0];
            etlf_pkg::CFG_MIN_TREND: min_trend_q = value[MIN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid and wait until every forecast owed has come back.
    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_forecasts.size() != 0)
            @(posedge clk);
    endtask

    // Offer one sample beat after a random gap, hold it until taken, then
    // log the forecast it owes. Valid stays high on return so that a
    // zero-gap beat follows without a bubble.
    task automatic send(logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] m,
                        bit typed, forecast_t typed_want);
        int        gap;
        forecast_t want;
        gap = quiet ? 0 : $urandom_range(0, 8);
        cfg_write <= 1'b0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        cpu_sample   <= c;
        mem_sample   <= m;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        want = predict_forecast(c, m);
        if (typed)
            pending_forecasts.push_back(typed_want);
        else
            pending_forecasts.push_back(want);
    endtask

    // Receiver: stall a random number of cycles before each forecast beat,
    // then take it as soon as it shows.
    initial
    begin : result_side
        int hold;
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    function automatic void check_field(string label, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
            error_count++;
        end
    endfunction

    // Compare each forecast beat taken against the oldest one owed.
    always @(posedge clk)
    begin : forecast_check
        forecast_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_forecasts.size() == 0)
            begin
                $display("%0t: forecast beat with nothing pending", $time);
                error_count++;
            end
            else
            begin
                want = pending_forecasts.pop_front();
                check_field("cpu_forecast", want.cpu_fc, cpu_forecast);
                check_field("mem_forecast", want.mem_fc, mem_forecast);
                check_field("cpu_slope",    want.cpu_sl, cpu_slope);
                check_field("mem_slope",    want.mem_sl, mem_slope);
                check_field("cpu_level",    want.cpu_lv, cpu_level);
                check_field("mem_level",    want.mem_lv, mem_level);
                check_field("samples_held", want.held,   samples_held);
            end
        end
    end

    // Hard stop if the block hangs.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** ema_trend_load_forecaster_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        plan_row_t plan [$];
        forecast_t no_want;
        int        i;
        int        p;
        int        ch;
        int        pick;
        logic [SAMPLE_W-1:0] c;
        logic [SAMPLE_W-1:0] m;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First sample seeds the level; cpu above 100% saturates.
        plan.push_back(checked(15'd32767, 15'd0, 15'd25600, 15'd0,
                               23'd6553600, 23'd0, 6'd1));
        // Second sample under the reset alpha: cpu stays at full scale,
        // mem moves 30% of the way from 0 to 100% (again saturated).
        plan.push_back(checked(15'd25600, 15'd25601, 15'd25600, 15'd7680,
                               23'd6553600, 23'd1966100, 6'd2));
        // Lowest trend threshold and longest horizon: slopes appear early
        // and forecasts hit both clamps.
        plan.push_back(setting(etlf_pkg::CFG_MIN_TREND, 16'd2));
        plan.push_back(setting(etlf_pkg::CFG_HORIZON, 16'd255));
        plan.push_back(beat(15'd0, 15'd25600));
        plan.push_back(beat(15'd1, 15'd16384));
        plan.push_back(beat(15'd25599, 15'd0));
        plan.push_back(beat(15'd16384, 15'd10922));
        // Zero alpha: the level holds its value.
        plan.push_back(setting(etlf_pkg::CFG_ALPHA, 16'd0));
        plan.push_back(beat(15'd12800, 15'd12800));
        plan.push_back(beat(15'd25600, 15'd0));
        // Full alpha with no look-ahead.
        plan.push_back(setting(etlf_pkg::CFG_ALPHA, 16'd65535));
        plan.push_back(setting(etlf_pkg::CFG_HORIZON, 16'd0));
        plan.push_back(beat(15'd0, 15'd0));
        plan.push_back(beat(15'd32767, 15'd32767));
        plan.push_back(beat(15'd100, 15'd200));
        // Threshold beyond the window depth: slopes must stay zero.
        plan.push_back(setting(etlf_pkg::CFG_MIN_TREND, 16'd63));
        plan.push_back(setting(etlf_pkg::CFG_HORIZON, 16'd255));
        plan.push_back(beat(15'd25600, 15'd0));
        plan.push_back(beat(15'd0, 15'd25600));
        plan.push_back(beat(15'd21845, 15'd10922));
        // Back to the reset settings.
        plan.push_back(setting(etlf_pkg::CFG_ALPHA, etlf_pkg::ALPHA_RESET));
        plan.push_back(setting(etlf_pkg::CFG_HORIZON, 16'(etlf_pkg::HORIZON_RESET)));
        plan.push_back(setting(etlf_pkg::CFG_MIN_TREND, 16'(etlf_pkg::MIN_RESET)));
        plan.push_back(beat(15'd25600, 15'd25600));
        plan.push_back(beat(15'd0, 15'd0));
        plan.push_back(beat(15'd12345, 15'd6789));
        plan.push_back(beat(15'd25601, 15'd30000));

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                set_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send(plan[i].cpu, plan[i].mem, plan[i].typed, plan[i].want);
        end

        // Random phases. The first few pin the register extremes and reset values, the rest
        // draw them; the window carries over, so it fills and wraps early.
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            set_reg(etlf_pkg::CFG_ALPHA,
                    (p == 0) ? 16'd65535 :
                    (p == 1) ? 16'd0 :
                    (p == 2) ? etlf_pkg::ALPHA_RESET : 16'($urandom_range(0, 65535)));
            set_reg(etlf_pkg::CFG_HORIZON,
                    (p == 0) ? 16'd255 :
                    (p == 1) ? 16'd0 :
                    (p == 2) ? 16'(etlf_pkg::HORIZON_RESET) :
                               16'($urandom_range(0, 255)));
            set_reg(etlf_pkg::CFG_MIN_TREND,
                    (p == 0) ? 16'd2 :
                    (p == 1) ? 16'd60 :
                    (p == 2) ? 16'(etlf_pkg::MIN_RESET) :
                    (p == 3) ? 16'd63 : 16'($urandom_range(2, 60)));
            for (i = 0; i < BEATS_PER_PHASE; i++)
            begin
                if (burst_left == 0)
                begin
                    // Mostly trending bursts, which is what drives the slope
                    // and clamp logic; some spread, noise and flat lines.
                    pick  = $urandom_range(0, 9);
                    shape = (pick < 5) ? SHAPE_RAMP :
                            (pick < 7) ? SHAPE_SPREAD :
                            (pick < 8) ? SHAPE_NOISE : SHAPE_FLAT;
                    for (ch = 0; ch < 2; ch++)
                    begin
                        if ($urandom_range(0, 2) == 0)
                            track[ch] = $urandom_range(0, 1) ? FULL_SCALE : 0;
                        else
                            track[ch] = $urandom_range(0, FULL_SCALE);
                        drift[ch] = $urandom_range(0, 800) - 400;
                    end
                    burst_left = $urandom_range(8, 70);
                    quiet      = ($urandom_range(0, 3) == 0);
                end
                burst_left--;
                c = next_sample(0);
                m = next_sample(1);
                send(c, m, 1'b0, no_want);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** ema_trend_load_forecaster_core: PASSED **");
        else
            $display("** ema_trend_load_forecaster_core: FAILED **");
        $finish;
    end

endmodule
